[design/wgm_pkg.sv]
// Shared types, constants and helper functions for the wildcard glob matcher.
`timescale 1ns / 1ps

package wgm_pkg;

    // Element store size and derived widths
    localparam int PAT_SLOTS = 64;
    localparam int IDX_W     = $clog2(PAT_SLOTS);
    localparam int CNT_W     = $clog2(PAT_SLOTS + 1);

    // One bit per NFA position, 0..PAT_SLOTS
    typedef logic [PAT_SLOTS:0]   t_pos;
    // One bit per element slot
    typedef logic [PAT_SLOTS-1:0] t_slot_vec;

    // Compiled pattern element kinds
    typedef enum logic [2:0] {
        EL_LIT = 3'd0,   // literal byte (stored case folded)
        EL_ANY = 3'd1,   // any one byte
        EL_RUN = 3'd2,   // any run, possibly empty
        EL_NSP = 3'd3,   // run of non-space bytes, possibly empty
        EL_SPC = 3'd4    // one or more spaces
    } t_el_type;

    typedef struct packed {
        t_el_type   kind;
        logic [7:0] ch;
    } t_elem;

    // Pattern metacharacters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    // ASCII upper case to lower case, everything else unchanged
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

    // Epsilon closure over run elements: an active position whose element is
    // a run also activates the next one, chained. Done with one carry chain:
    // the carries into each bit are exactly the positions reached.
    function automatic t_pos closure(input t_pos x, input t_pos p);
        t_pos a;
        t_pos s;
        a = x & p;
        s = a + p;
        return x | (s ^ a ^ p);
    endfunction

endpackage

[design/wildcard_glob_matcher.sv]
// Top level of the wildcard glob matcher: pattern compiler, NFA state, result stages.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per byte. kind 0
//   words load a pattern, compiled on the fly into up to PAT_SLOTS elements;
//   kind 1 words stream a subject. A word with last set ends the pattern or
//   the subject; no_byte marks a word with no byte (empty string end).
//   The first pattern word after a closed pattern starts a new pattern.
//   Each subject word with last set produces one result word on the output
//   channel (o_out_valid / i_out_ready): matched and pattern_overflow.
//   Config: i_cfg_we writes i_cfg_wdata into extended_mode (write only while
//   idle); it enables the percent, tilde and backslash wildcards.
//   Throughput: one word per cycle, pattern or subject, while o_in_ready
//   is high; the NFA update is one carry chain plus per-element compares
//   between state registers. The result of a final subject word passes
//   through a snapshot stage, then the output register.
//   When the receiver stalls, the output register and the snapshot stage hold
//   two results; o_in_ready drops only while both are full.
//   Reset (synchronous, active low) empties the pattern, clears flags, sets
//   the NFA to its start position and clears extended_mode. No clearing pass.
module wildcard_glob_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_char_code,
    input  logic       i_no_byte,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_pattern_overflow,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    localparam wgm_pkg::t_pos START = wgm_pkg::t_pos'(1);

    // Pattern state
    logic                      r_ext;
    logic [wgm_pkg::CNT_W-1:0] r_count, n_count;
    wgm_pkg::t_slot_vec        r_live, n_live;
    wgm_pkg::t_slot_vec        r_skip, n_skip;
    wgm_pkg::t_el_type         r_last_type, n_last_type;
    logic                      r_esc, n_esc;
    logic                      r_abs, n_abs;
    logic                      r_ovf, n_ovf;
    logic                      r_closed, n_closed;
    wgm_pkg::t_elem            r_elem [wgm_pkg::PAT_SLOTS];

    // Subject state
    wgm_pkg::t_pos             r_act, n_act;
    logic                      r_seen, n_seen;

    // Snapshot stage
    logic                      r_fin_vld, n_fin_vld;
    wgm_pkg::t_pos             r_fin_act, n_fin_act;
    wgm_pkg::t_pos             r_fin_skip, n_fin_skip;
    logic [wgm_pkg::CNT_W-1:0] r_fin_n, n_fin_n;
    logic                      r_fin_ok, n_fin_ok;
    logic                      r_fin_ovf, n_fin_ovf;

    // Output register
    logic                      r_out_vld;
    logic                      r_out_hit;
    logic                      r_out_ovf;

    // Element write port
    logic                      w_en;
    logic [wgm_pkg::IDX_W-1:0] w_idx;
    wgm_pkg::t_elem            w_elem;

    logic                      acc;
    logic                      out_take;
    wgm_pkg::t_pos             step_next;
    wgm_pkg::t_pos             fin_cl;
    logic                      fin_hit;

    // Handshake
    assign out_take    = !r_out_vld || i_out_ready;
    assign o_in_ready  = !r_fin_vld || out_take;
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_matched   = r_out_hit;
    assign o_pattern_overflow = r_out_ovf;

    // NFA transition for a subject byte
    wgm_nfa_step u_step (
        .i_act  (r_act),
        .i_skip ({1'b0, r_skip}),
        .i_live (r_live),
        .i_elem (r_elem),
        .i_char (i_char_code),
        .o_next (step_next)
    );

    // Pattern compile and subject step
    always_comb begin
        wgm_pkg::t_el_type add_type;
        logic              add_en;
        logic [7:0]        add_ch;
        logic              has_last;

        n_count     = r_count;
        n_live      = r_live;
        n_skip      = r_skip;
        n_last_type = r_last_type;
        n_esc       = r_esc;
        n_abs       = r_abs;
        n_ovf       = r_ovf;
        n_closed    = r_closed;
        n_act       = r_act;
        n_seen      = r_seen;
        n_fin_vld   = r_fin_vld && !out_take;
        n_fin_act   = r_fin_act;
        n_fin_skip  = r_fin_skip;
        n_fin_n     = r_fin_n;
        n_fin_ok    = r_fin_ok;
        n_fin_ovf   = r_fin_ovf;
        add_en      = 1'b0;
        add_type    = wgm_pkg::EL_LIT;
        add_ch      = i_char_code;
        has_last    = 1'b0;
        w_en        = 1'b0;
        w_idx       = r_count[wgm_pkg::IDX_W-1:0];
        w_elem      = '{kind: wgm_pkg::EL_LIT, ch: wgm_pkg::fold(i_char_code)};

        if (acc && !i_kind) begin
            // first word of a new pattern
            if (r_closed) begin
                n_count  = '0;
                n_live   = '0;
                n_skip   = '0;
                n_esc    = 1'b0;
                n_abs    = 1'b0;
                n_ovf    = 1'b0;
                n_closed = 1'b0;
                n_act    = START;
                n_seen   = 1'b0;
            end
            has_last = (n_count != '0);
            if (!i_no_byte) begin
                if (n_esc) begin
                    n_esc  = 1'b0;
                    n_abs  = 1'b0;
                    add_en = 1'b1;
                end else if (r_ext && n_abs &&
                             (i_char_code == wgm_pkg::CH_TILDE ||
                              i_char_code == wgm_pkg::CH_SPACE)) begin
                    // swallowed after a tilde
                end else begin
                    n_abs = 1'b0;
                    if (r_ext && i_char_code == wgm_pkg::CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (i_char_code == wgm_pkg::CH_STAR) begin
                        add_type = wgm_pkg::EL_RUN;
                        add_en   = !(has_last && r_last_type == wgm_pkg::EL_RUN);
                    end else if (i_char_code == wgm_pkg::CH_QUEST) begin
                        add_type = wgm_pkg::EL_ANY;
                        add_en   = 1'b1;
                    end else if (r_ext && i_char_code == wgm_pkg::CH_PCT) begin
                        add_type = wgm_pkg::EL_NSP;
                        add_en   = !(has_last && r_last_type == wgm_pkg::EL_NSP);
                    end else if (r_ext && i_char_code == wgm_pkg::CH_TILDE) begin
                        add_type = wgm_pkg::EL_SPC;
                        add_en   = 1'b1;
                        n_abs    = 1'b1;
                    end else begin
                        add_en = 1'b1;
                    end
                end
            end
            // append the element or flag overflow
            if (add_en) begin
                if (n_count < wgm_pkg::CNT_W'(wgm_pkg::PAT_SLOTS)) begin
                    w_en                                 = 1'b1;
                    w_idx                                = n_count[wgm_pkg::IDX_W-1:0];
                    w_elem                               = '{kind: add_type,
                                                             ch: wgm_pkg::fold(add_ch)};
                    n_live[n_count[wgm_pkg::IDX_W-1:0]] = 1'b1;
                    n_skip[n_count[wgm_pkg::IDX_W-1:0]] =
                        (add_type == wgm_pkg::EL_RUN) || (add_type == wgm_pkg::EL_NSP);
                    n_last_type                          = add_type;
                    n_count                              = n_count + wgm_pkg::CNT_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
            if (i_last) begin
                n_closed = 1'b1;
                n_esc    = 1'b0;
                n_abs    = 1'b0;
            end
        end else if (acc && i_kind) begin
            if (!i_no_byte) begin
                n_act  = step_next;
                n_seen = 1'b1;
            end
            // end of subject: snapshot for the final check, restart NFA
            if (i_last) begin
                n_fin_vld  = 1'b1;
                n_fin_act  = n_act;
                n_fin_skip = {1'b0, r_skip};
                n_fin_n    = r_count;
                n_fin_ok   = n_seen && (r_count != '0) && !r_ovf;
                n_fin_ovf  = r_ovf;
                n_act      = START;
                n_seen     = 1'b0;
            end
        end
    end

    // Final acceptance check on the snapshot
    assign fin_cl  = wgm_pkg::closure(r_fin_act, r_fin_skip);
    assign fin_hit = r_fin_ok && fin_cl[r_fin_n];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext     <= 1'b0;
            r_count   <= '0;
            r_live    <= '0;
            r_skip    <= '0;
            r_esc     <= 1'b0;
            r_abs     <= 1'b0;
            r_ovf     <= 1'b0;
            r_closed  <= 1'b0;
            r_act     <= START;
            r_seen    <= 1'b0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_ext <= i_cfg_wdata;
            r_count   <= n_count;
            r_live    <= n_live;
            r_skip    <= n_skip;
            r_esc     <= n_esc;
            r_abs     <= n_abs;
            r_ovf     <= n_ovf;
            r_closed  <= n_closed;
            r_act     <= n_act;
            r_seen    <= n_seen;
            r_fin_vld <= n_fin_vld;
            if (out_take) r_out_vld <= r_fin_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last_type <= n_last_type;
        r_fin_act   <= n_fin_act;
        r_fin_skip  <= n_fin_skip;
        r_fin_n     <= n_fin_n;
        r_fin_ok    <= n_fin_ok;
        r_fin_ovf   <= n_fin_ovf;
        if (out_take) begin
            r_out_hit <= fin_hit;
            r_out_ovf <= r_fin_ovf;
        end
    end

    // Element store
    always_ff @(posedge i_clk) begin
        if (w_en) r_elem[w_idx] <= w_elem;
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wgm_pkg::CNT_W'(wgm_pkg::PAT_SLOTS))
        else $error("element count beyond store size");

    a_act_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act & ~{r_live, 1'b1}) == '0)
        else $error("active position beyond compiled pattern");

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld && out_take && r_fin_ovf |=> !r_out_hit)
        else $error("match reported on overflowed pattern");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_fin_vld && r_out_vld && !i_out_ready)
        else $error("input stalled without full result stages");

endmodule

[design/wgm_nfa_step.sv]
// One subject byte through the bit-parallel NFA: next active position set.
`timescale 1ns / 1ps

module wgm_nfa_step (
    input  wgm_pkg::t_pos      i_act,
    input  wgm_pkg::t_pos      i_skip,
    input  wgm_pkg::t_slot_vec i_live,
    input  wgm_pkg::t_elem     i_elem [wgm_pkg::PAT_SLOTS],
    input  logic [7:0]         i_char,
    output wgm_pkg::t_pos      o_next
);

    wgm_pkg::t_pos cur;
    logic [7:0]    f;
    logic          is_sp;

    assign f     = wgm_pkg::fold(i_char);
    assign is_sp = (i_char == wgm_pkg::CH_SPACE);
    assign cur   = wgm_pkg::closure(i_act, i_skip);

    // Per-element transitions, all elements in parallel
    always_comb begin
        o_next = '0;
        for (int i = 0; i < wgm_pkg::PAT_SLOTS; i++) begin
            if (i_live[i] && cur[i]) begin
                case (i_elem[i].kind)
                    wgm_pkg::EL_LIT: begin
                        if (i_elem[i].ch == f) o_next[i+1] = 1'b1;
                    end
                    wgm_pkg::EL_ANY: o_next[i+1] = 1'b1;
                    wgm_pkg::EL_RUN: o_next[i] = 1'b1;
                    wgm_pkg::EL_NSP: begin
                        if (!is_sp) o_next[i] = 1'b1;
                    end
                    wgm_pkg::EL_SPC: begin
                        if (is_sp) o_next[i+1] = 1'b1;
                    end
                    default: ;
                endcase
            end
            // space run stays satisfied on further spaces
            if (i_live[i] && i_elem[i].kind == wgm_pkg::EL_SPC && cur[i+1] && is_sp) begin
                o_next[i+1] = 1'b1;
            end
        end
    end

endmodule

[test/wgm_checker.sv]
// Checker for the wildcard glob matcher: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module wgm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_char_code,
    input  logic       i_no_byte,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_matched,
    input  logic       i_pattern_overflow,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    output int         o_fail_count,
    output int         o_due,
    output int         o_result_count,
    output int         o_hit_count,
    output int         o_ovf_count
);

    typedef struct packed {
        logic hit;
        logic ovf;
    } t_verdict;

    // Shadow of the compiled pattern and the NFA
    wgm_pkg::t_el_type el_kind [wgm_pkg::PAT_SLOTS];
    logic [7:0]        el_ch   [wgm_pkg::PAT_SLOTS];
    int                el_cnt;
    wgm_pkg::t_pos     live_q;
    logic              esc_q, absorb_q, ovf_q, seen_q, closed_q;
    logic              ext_mode;

    t_verdict   verdicts_due[$];
    int         fails   = 0;
    int         results = 0;
    int         hits    = 0;
    int         ovfs    = 0;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= wgm_pkg::CH_UP_A && c <= wgm_pkg::CH_UP_Z) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Spread activity across run-like elements (they may match nothing)
    function automatic wgm_pkg::t_pos reach_runs(input wgm_pkg::t_pos s);
        for (int i = 0; i < el_cnt; i++) begin
            if (s[i] && (el_kind[i] == wgm_pkg::EL_RUN || el_kind[i] == wgm_pkg::EL_NSP)) begin
                s[i+1] = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic void restart_subject();
        live_q    = '0;
        live_q[0] = 1'b1;
        seen_q    = 1'b0;
    endfunction

    function automatic void push_element(input wgm_pkg::t_el_type k, input logic [7:0] c);
        if (el_cnt < wgm_pkg::PAT_SLOTS) begin
            el_kind[el_cnt] = k;
            el_ch[el_cnt]   = c;
            el_cnt++;
        end else begin
            ovf_q = 1'b1;
        end
    endfunction

    function automatic logic tail_is(input wgm_pkg::t_el_type k);
        return el_cnt > 0 && el_kind[el_cnt-1] == k;
    endfunction

    function automatic void compile_pattern_byte(input logic [7:0] c);
        // quoted byte is always literal
        if (esc_q) begin
            esc_q    = 1'b0;
            absorb_q = 1'b0;
            push_element(wgm_pkg::EL_LIT, c);
            return;
        end
        // tilde swallows following tildes and spaces
        if (ext_mode && absorb_q && (c == wgm_pkg::CH_TILDE || c == wgm_pkg::CH_SPACE)) begin
            return;
        end
        absorb_q = 1'b0;
        if (ext_mode && c == wgm_pkg::CH_BSLASH) begin
            esc_q = 1'b1;
        end else if (c == wgm_pkg::CH_STAR) begin
            if (!tail_is(wgm_pkg::EL_RUN)) begin
                push_element(wgm_pkg::EL_RUN, 8'h00);
            end
        end else if (c == wgm_pkg::CH_QUEST) begin
            push_element(wgm_pkg::EL_ANY, 8'h00);
        end else if (ext_mode && c == wgm_pkg::CH_PCT) begin
            if (!tail_is(wgm_pkg::EL_NSP)) begin
                push_element(wgm_pkg::EL_NSP, 8'h00);
            end
        end else if (ext_mode && c == wgm_pkg::CH_TILDE) begin
            push_element(wgm_pkg::EL_SPC, 8'h00);
            absorb_q = 1'b1;
        end else begin
            push_element(wgm_pkg::EL_LIT, c);
        end
    endfunction

    function automatic void step_nfa(input logic [7:0] c);
        wgm_pkg::t_pos cur;
        wgm_pkg::t_pos nxt;
        logic [7:0]    f;
        f   = fold_case(c);
        cur = reach_runs(live_q);
        nxt = '0;
        for (int i = 0; i < el_cnt; i++) begin
            case (el_kind[i])
                wgm_pkg::EL_LIT: begin
                    if (cur[i] && fold_case(el_ch[i]) == f) nxt[i+1] = 1'b1;
                end
                wgm_pkg::EL_ANY: begin
                    if (cur[i]) nxt[i+1] = 1'b1;
                end
                wgm_pkg::EL_RUN: begin
                    if (cur[i]) nxt[i] = 1'b1;
                end
                wgm_pkg::EL_NSP: begin
                    if (cur[i] && c != wgm_pkg::CH_SPACE) nxt[i] = 1'b1;
                end
                wgm_pkg::EL_SPC: begin
                    // entering or staying inside a space run
                    if ((cur[i] || cur[i+1]) && c == wgm_pkg::CH_SPACE) nxt[i+1] = 1'b1;
                end
                default: ;
            endcase
        end
        live_q = nxt;
        seen_q = 1'b1;
    endfunction

    // Predict the effect of one accepted input word
    function automatic void apply_word(input logic k, input logic [7:0] c,
                                       input logic nb, input logic lst);
        wgm_pkg::t_pos fin;
        t_verdict      v;
        if (k == 1'b0) begin
            if (closed_q) begin
                el_cnt   = 0;
                esc_q    = 1'b0;
                absorb_q = 1'b0;
                ovf_q    = 1'b0;
                closed_q = 1'b0;
                restart_subject();
            end
            if (!nb) compile_pattern_byte(c);
            if (lst) begin
                closed_q = 1'b1;
                esc_q    = 1'b0;
                absorb_q = 1'b0;
            end
        end else begin
            if (!nb) step_nfa(c);
            if (lst) begin
                fin   = reach_runs(live_q);
                v.hit = !ovf_q && el_cnt > 0 && seen_q && fin[el_cnt];
                v.ovf = ovf_q;
                verdicts_due.push_back(v);
                restart_subject();
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_verdict v;
        if (!i_rst_n) begin
            el_cnt   = 0;
            esc_q    = 1'b0;
            absorb_q = 1'b0;
            ovf_q    = 1'b0;
            closed_q = 1'b0;
            ext_mode = 1'b0;
            restart_subject();
            verdicts_due.delete();
        end else begin
            if (i_cfg_we) ext_mode = i_cfg_wdata;
            // result side
            if (i_out_valid && i_out_ready) begin
                results++;
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result word: matched %0b, pattern_overflow %0b",
                           i_matched, i_pattern_overflow);
                    fails++;
                end else begin
                    v = verdicts_due.pop_front();
                    if (v.hit) hits++;
                    if (v.ovf) ovfs++;
                    if (i_matched !== v.hit) begin
                        $error("matched: expected %0b, actual %0b", v.hit, i_matched);
                        fails++;
                    end
                    if (i_pattern_overflow !== v.ovf) begin
                        $error("pattern_overflow: expected %0b, actual %0b",
                               v.ovf, i_pattern_overflow);
                        fails++;
                    end
                end
            end
            // input side
            if (i_in_valid && i_in_ready) begin
                apply_word(i_kind, i_char_code, i_no_byte, i_last);
            end
        end
        o_due          <= verdicts_due.size();
        o_fail_count   <= fails;
        o_result_count <= results;
        o_hit_count    <= hits;
        o_ovf_count    <= ovfs;
    end

endmodule

[test/testbench.sv]
// Testbench top for the wildcard glob matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       kind;
    logic [7:0] char_code;
    logic       no_byte;
    logic       last;
    logic       out_valid;
    logic       out_ready;
    logic       matched;
    logic       pattern_overflow;
    logic       cfg_we;
    logic       cfg_wdata;

    int fail_count, due, result_count, hit_count, ovf_count;

    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         hold_req    = 0;
    int         hold_left   = 0;
    int         words_sent  = 0;
    logic       ext_on      = 1'b0;
    logic [7:0] pat_q[$];
    logic [7:0] subj_q[$];

    wildcard_glob_matcher u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_kind             (kind),
        .i_char_code        (char_code),
        .i_no_byte          (no_byte),
        .i_last             (last),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_matched          (matched),
        .o_pattern_overflow (pattern_overflow),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata)
    );

    wgm_checker u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_kind             (kind),
        .i_char_code        (char_code),
        .i_no_byte          (no_byte),
        .i_last             (last),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_matched          (matched),
        .i_pattern_overflow (pattern_overflow),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .o_fail_count       (fail_count),
        .o_due              (due),
        .o_result_count     (result_count),
        .o_hit_count        (hit_count),
        .o_ovf_count        (ovf_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #3_000_000;
        $display("Timeout with %0d results still due", due);
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        logic [7:0] l;
        l = c | wgm_pkg::CASE_BIT;
        if (l >= "a" && l <= "z" && $urandom_range(1) == 1) return c ^ wgm_pkg::CASE_BIT;
        return c;
    endfunction

    function automatic logic [7:0] letter();
        return flip_case("a" + 8'($urandom_range(2)));
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30) return letter();
        if (r < 40) return wgm_pkg::CH_SPACE;
        if (r < 50) return wgm_pkg::CH_STAR;
        if (r < 58) return wgm_pkg::CH_QUEST;
        if (r < 65) return wgm_pkg::CH_PCT;
        if (r < 72) return wgm_pkg::CH_TILDE;
        if (r < 78) return wgm_pkg::CH_BSLASH;
        return 8'($urandom_range(255));
    endfunction

    // One word on the input channel, with a random gap before it
    task automatic send_word(input logic k, input logic [7:0] c,
                             input logic nb, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        char_code <= c;
        no_byte   <= nb;
        last      <= lst;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        if (!(nb && !lst)) words_sent++;
    endtask

    // Drain all results and let in-flight pattern words settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic build_pattern();
        int r;
        int len;
        pat_q.delete();
        r = $urandom_range(99);
        if (r < 5) len = 0;
        else if (r < 10) len = $urandom_range(60, 72);
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            if (len > 8 && $urandom_range(9) != 0) pat_q.push_back(letter());
            else pat_q.push_back(pick_pattern_byte());
        end
    endtask

    // Subject that mostly fits the pattern, sometimes spoiled
    task automatic build_subject();
        int         i;
        logic [7:0] c;
        subj_q.delete();
        if ($urandom_range(99) < 8) return;
        i = 0;
        while (i < pat_q.size()) begin
            c = pat_q[i];
            if (ext_on && c == wgm_pkg::CH_BSLASH && i + 1 < pat_q.size()) begin
                subj_q.push_back(flip_case(pat_q[i+1]));
                i++;
            end else if (c == wgm_pkg::CH_STAR) begin
                repeat ($urandom_range(3)) begin
                    subj_q.push_back($urandom_range(3) == 0 ? wgm_pkg::CH_SPACE : letter());
                end
            end else if (c == wgm_pkg::CH_QUEST) begin
                subj_q.push_back(8'($urandom_range(255)));
            end else if (ext_on && c == wgm_pkg::CH_PCT) begin
                repeat ($urandom_range(3)) subj_q.push_back(letter());
            end else if (ext_on && c == wgm_pkg::CH_TILDE) begin
                repeat ($urandom_range(1, 2)) subj_q.push_back(wgm_pkg::CH_SPACE);
                while (i + 1 < pat_q.size() &&
                       (pat_q[i+1] == wgm_pkg::CH_TILDE ||
                        pat_q[i+1] == wgm_pkg::CH_SPACE)) begin
                    i++;
                end
            end else begin
                subj_q.push_back(flip_case(c));
            end
            i++;
        end
        if (subj_q.size() > 0 && $urandom_range(99) < 25) begin
            subj_q[$urandom_range(subj_q.size() - 1)] = letter();
        end
    endtask

    task automatic send_pattern();
        if (pat_q.size() == 0) begin
            send_word(1'b0, 8'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
            for (int i = 0; i < pat_q.size(); i++) begin
                send_word(1'b0, pat_q[i], 1'b0, i == pat_q.size() - 1);
            end
        end
    endtask

    task automatic send_subject();
        if (subj_q.size() == 0) begin
            send_word(1'b1, 8'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
            for (int i = 0; i < subj_q.size(); i++) begin
                // stray empty word, ignored by the block
                if ($urandom_range(99) < 3) send_word(1'b1, 8'($urandom_range(255)), 1'b1, 1'b0);
                send_word(1'b1, subj_q[i], 1'b0, i == subj_q.size() - 1);
            end
        end
    endtask

    // Random patterns, each followed by a few subjects, with some noise words
    task automatic run_batch(input int n);
        int goal;
        int n_subj;
        goal = words_sent + n;
        while (words_sent < goal) begin
            if ($urandom_range(99) < 8) begin
                send_word(1'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                build_pattern();
                send_pattern();
                n_subj = $urandom_range(1, 4);
                for (int s = 0; s < n_subj && words_sent < goal; s++) begin
                    build_subject();
                    send_subject();
                end
            end
        end
    endtask

    initial begin
        in_valid  <= 1'b0;
        kind      <= 1'b0;
        char_code <= 8'h00;
        no_byte   <= 1'b0;
        last      <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        i_rst_n   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        @(posedge i_clk);

        // Directed, plain mode: byte zero, 0xFF, case folding, empty strings,
        // ignored empty word, subject checked while the pattern still loads
        send_word(1'b0, wgm_pkg::CH_QUEST, 1'b0, 1'b1);
        send_word(1'b1, 8'h00, 1'b0, 1'b1);
        send_word(1'b0, 8'hFF, 1'b0, 1'b0);
        send_word(1'b0, "A", 1'b0, 1'b1);
        send_word(1'b1, 8'hFF, 1'b0, 1'b0);
        send_word(1'b1, "a", 1'b0, 1'b1);
        send_word(1'b0, 8'h00, 1'b1, 1'b1);
        send_word(1'b1, 8'hFF, 1'b1, 1'b1);
        send_word(1'b0, "b", 1'b0, 1'b0);
        send_word(1'b1, "B", 1'b0, 1'b1);
        send_word(1'b0, 8'h00, 1'b1, 1'b0);
        send_word(1'b0, wgm_pkg::CH_STAR, 1'b0, 1'b1);
        send_word(1'b1, "b", 1'b0, 1'b0);
        send_word(1'b1, "q", 1'b0, 1'b1);

        // Directed, extended mode: quoting, tilde absorption, percent collapse,
        // trailing backslash dropped
        settle();
        write_mode(1'b1);
        ext_on = 1'b1;
        send_word(1'b0, wgm_pkg::CH_BSLASH, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_STAR, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_TILDE, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_SPACE, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_TILDE, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_PCT, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_PCT, 1'b0, 1'b0);
        send_word(1'b0, wgm_pkg::CH_BSLASH, 1'b0, 1'b1);
        send_word(1'b1, wgm_pkg::CH_STAR, 1'b0, 1'b0);
        send_word(1'b1, wgm_pkg::CH_SPACE, 1'b0, 1'b0);
        send_word(1'b1, "x", 1'b0, 1'b1);

        // Back-pressure: receiver holds off while one-byte subjects keep coming
        settle();
        write_mode(1'b0);
        ext_on = 1'b0;
        send_word(1'b0, wgm_pkg::CH_STAR, 1'b0, 1'b1);
        hold_req = 300;
        repeat (30) send_word(1'b1, letter(), 1'b0, 1'b1);

        // Random phases over handshake pressure and both mode settings
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            ext_on = (ph >= 4);
            write_mode(ext_on);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            run_batch(60);
        end

        settle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d input words over 8 random phases, both modes and a long stall;",
                 words_sent);
        $display("checked %0d results: %0d matches, %0d with pattern overflow.",
                 result_count, hit_count, ovf_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
